/* rtl/altab_pkg.sv */
package altab_pkg;

    localparam int LEASE_ENTRIES = 16;
    localparam int PROBE_LIMIT   = 2;

    localparam int IDX_W = (LEASE_ENTRIES > 1) ? $clog2(LEASE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(LEASE_ENTRIES + 1);
    localparam int PRB_W = $clog2(PROBE_LIMIT + 1);

    localparam int HW_W   = 48;
    localparam int ADDR_W = 32;
    localparam int ENT_W  = HW_W + ADDR_W;
    localparam int PADDR_W = 4;

    localparam logic [ADDR_W-1:0] SERVER_ADDR_RST = 32'hC0A8_0101;
    localparam logic [ADDR_W-1:0] POOL_FIRST_RST  = 32'hC0A8_0101;
    localparam logic [ADDR_W-1:0] POOL_LAST_RST   = 32'hC0A8_01FD;
    localparam logic [ADDR_W-1:0] SUBNET_MASK_RST = 32'hFFFF_FF00;

    localparam logic [1:0] REG_SERVER_ADDR = 2'd0;
    localparam logic [1:0] REG_POOL_FIRST  = 2'd1;
    localparam logic [1:0] REG_POOL_LAST   = 2'd2;
    localparam logic [1:0] REG_SUBNET_MASK = 2'd3;

    localparam logic CMD_DISCOVER = 1'b0;
    localparam logic CMD_REQUEST  = 1'b1;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_OFFER = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_NAK   = 2'd3;

    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_SUBNET = 2'd1;
    localparam logic [1:0] CAUSE_POOL   = 2'd2;
    localparam logic [1:0] CAUSE_OWNED  = 2'd3;

endpackage

/* rtl/address_lease_table_engine.sv */
// each word takes k = 1 to PROBE_LIMIT + 1 table scans of LEASE_ENTRIES entries; a request
// rejected on identifier, subnet or pool answers without a table scan
// one word at a time, the single-port lease memory being read once per entry per scan;
// busy stays high until the result strobe
// the receiver cannot stall: done is high for exactly one cycle with the result
// reset: rst_n asynchronous active low, clears the valid bits and loads register defaults
module address_lease_table_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [altab_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [47:0]                   client_hw,
    input  logic                          has_wanted,
    input  logic [31:0]                   wanted_addr,
    input  logic                          has_server_ident,
    input  logic [31:0]                   server_ident,
    output logic                          done,
    output logic [1:0]                    reply_kind,
    output logic [31:0]                   given_addr,
    output logic                          outcome,
    output logic [1:0]                    nak_cause
);
    import altab_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE} state_t;
    // what the current scan is for
    typedef enum logic [1:0] {PH_LOOK, PH_PROBE, PH_WANT} phase_t;

    // configuration registers
    logic [ADDR_W-1:0] server_addr_reg, pool_first_reg, pool_last_reg, subnet_mask_reg;

    // lease memory: hardware address above, ip address below
    logic [ENT_W-1:0] mem [LEASE_ENTRIES];
    logic [ENT_W-1:0] rd_data_reg;
    logic [LEASE_ENTRIES-1:0] valid_reg;

    state_t state_reg;
    phase_t phase_reg;

    // latched word
    logic              cmd_reg;
    logic [HW_W-1:0]   hw_reg;
    logic [ADDR_W-1:0] tgt_reg;
    logic [PRB_W-1:0]  nprobe_reg;

    // scan sequencing and gathered flags
    logic [CNT_W-1:0]  cnt_reg;
    logic              pend_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic              hwf_reg, fr_reg, taken_reg, owned_reg;
    logic [IDX_W-1:0]  hw_idx_reg, fr_idx_reg;
    logic [ADDR_W-1:0] hw_addr_reg;

    // result
    logic              done_reg;
    logic [1:0]        kind_reg, cause_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              full_reg;

    // apb
    logic cfg_we;
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_SERVER_ADDR: prdata = server_addr_reg;
            REG_POOL_FIRST:  prdata = pool_first_reg;
            REG_POOL_LAST:   prdata = pool_last_reg;
            REG_SUBNET_MASK: prdata = subnet_mask_reg;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_addr_reg <= SERVER_ADDR_RST;
            pool_first_reg  <= POOL_FIRST_RST;
            pool_last_reg   <= POOL_LAST_RST;
            subnet_mask_reg <= SUBNET_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_SERVER_ADDR: server_addr_reg <= pwdata;
                REG_POOL_FIRST:  pool_first_reg  <= pwdata;
                REG_POOL_LAST:   pool_last_reg   <= pwdata;
                REG_SUBNET_MASK: subnet_mask_reg <= pwdata;
                default:         server_addr_reg <= server_addr_reg;
            endcase
        end
    end

    // pool helpers
    logic              srv_in;
    logic [ADDR_W-1:0] first_probe, probe_inc, probe_step, fallback;
    assign srv_in = (server_addr_reg >= pool_first_reg) && (server_addr_reg <= pool_last_reg);

    // skip the server's own address inside the pool
    function automatic logic [ADDR_W-1:0] skip_srv(input logic [ADDR_W-1:0] p,
                                                    input logic [ADDR_W-1:0] srv,
                                                    input logic [ADDR_W-1:0] lo,
                                                    input logic [ADDR_W-1:0] hi,
                                                    input logic sin);
        logic [ADDR_W-1:0] r;
        r = p;
        if (p == srv && sin)
            r = (p < hi) ? p + 1'b1 : lo;
        return r;
    endfunction

    assign first_probe = skip_srv(pool_first_reg, server_addr_reg, pool_first_reg,
                                  pool_last_reg, srv_in);
    assign probe_inc   = tgt_reg + 1'b1;
    assign probe_step  = (probe_inc > pool_last_reg) ? pool_first_reg : probe_inc;
    assign fallback    = (srv_in && pool_first_reg == server_addr_reg)
                         ? pool_first_reg + 1'b1 : pool_first_reg;

    // decision after a scan
    logic              fin, next_probe, wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_addr;
    logic [1:0]        fin_kind, fin_cause;
    logic [ADDR_W-1:0] fin_addr;
    logic              fin_full;
    logic              probe_end;
    logic [1:0]        ok_kind;

    assign ok_kind   = (cmd_reg == CMD_DISCOVER) ? KIND_OFFER : KIND_ACK;
    assign probe_end = (probe_step == pool_first_reg)
                       || (nprobe_reg + 1'b1 == PRB_W'(PROBE_LIMIT));

    always_comb
    begin
        fin        = 1'b0;
        next_probe = 1'b0;
        wr_en      = 1'b0;
        wr_idx     = fr_idx_reg;
        wr_addr    = tgt_reg;
        fin_kind   = KIND_NONE;
        fin_cause  = CAUSE_NONE;
        fin_addr   = '0;
        fin_full   = 1'b0;
        if (state_reg == S_DECIDE)
        begin
            case (phase_reg)
                PH_LOOK:
                begin
                    if (hwf_reg)
                    begin
                        fin      = 1'b1;
                        fin_kind = KIND_OFFER;
                        fin_addr = hw_addr_reg;
                    end
                end
                PH_PROBE:
                begin
                    if (!taken_reg)
                    begin
                        fin = 1'b1;
                        if (fr_reg)
                        begin
                            wr_en    = 1'b1;
                            fin_kind = ok_kind;
                            fin_addr = tgt_reg;
                        end
                        else
                        begin
                            fin_kind = (cmd_reg == CMD_DISCOVER) ? KIND_OFFER : KIND_NONE;
                            fin_full = 1'b1;
                        end
                    end
                    else if (owned_reg)
                    begin
                        fin      = 1'b1;
                        fin_kind = ok_kind;
                        fin_addr = tgt_reg;
                    end
                    else if (!probe_end)
                    begin
                        next_probe = 1'b1;
                    end
                    else
                    begin
                        // probes used up: fall back to the pool start
                        fin     = 1'b1;
                        wr_addr = fallback;
                        if (fr_reg)
                        begin
                            wr_en    = 1'b1;
                            fin_kind = ok_kind;
                            fin_addr = fallback;
                        end
                        else if (cmd_reg == CMD_DISCOVER)
                        begin
                            fin_kind = KIND_OFFER;
                            fin_addr = fallback;
                            fin_full = 1'b1;
                        end
                        else
                        begin
                            fin_full = 1'b1;
                        end
                    end
                end
                PH_WANT:
                begin
                    fin = 1'b1;
                    if (taken_reg && !owned_reg)
                    begin
                        fin_kind  = KIND_NAK;
                        fin_cause = CAUSE_OWNED;
                    end
                    else if (hwf_reg)
                    begin
                        wr_en    = 1'b1;
                        wr_idx   = hw_idx_reg;
                        fin_kind = KIND_ACK;
                        fin_addr = tgt_reg;
                    end
                    else if (fr_reg)
                    begin
                        wr_en    = 1'b1;
                        fin_kind = KIND_ACK;
                        fin_addr = tgt_reg;
                    end
                    else
                    begin
                        fin_full = 1'b1;
                    end
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase
        end
    end

    // lease memory port
    logic issue;
    assign issue = (state_reg == S_SCAN) && (cnt_reg < CNT_W'(LEASE_ENTRIES));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= {hw_reg, wr_addr};
        if (issue)
            rd_data_reg <= mem[cnt_reg[IDX_W-1:0]];
    end

    // entry under test
    logic              e_valid, hw_hit, addr_hit;
    assign e_valid  = valid_reg[pend_idx_reg];
    assign hw_hit   = e_valid && (rd_data_reg[ENT_W-1:ADDR_W] == hw_reg);
    assign addr_hit = e_valid && (rd_data_reg[ADDR_W-1:0] == tgt_reg);

    logic start_ok;
    assign start_ok = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_LOOK;
            valid_reg    <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            done_reg     <= 1'b0;
            cmd_reg      <= CMD_DISCOVER;
            hw_reg       <= '0;
            tgt_reg      <= '0;
            nprobe_reg   <= '0;
            hwf_reg      <= 1'b0;
            fr_reg       <= 1'b0;
            taken_reg    <= 1'b0;
            owned_reg    <= 1'b0;
            hw_idx_reg   <= '0;
            fr_idx_reg   <= '0;
            hw_addr_reg  <= '0;
            kind_reg     <= KIND_NONE;
            cause_reg    <= CAUSE_NONE;
            addr_reg     <= '0;
            full_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (wr_en)
                valid_reg[wr_idx] <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (start_ok)
                    begin
                        cmd_reg    <= cmd;
                        hw_reg     <= client_hw;
                        nprobe_reg <= '0;
                        cnt_reg    <= '0;
                        hwf_reg    <= 1'b0;
                        fr_reg     <= 1'b0;
                        taken_reg  <= 1'b0;
                        owned_reg  <= 1'b0;
                        kind_reg   <= KIND_NONE;
                        cause_reg  <= CAUSE_NONE;
                        addr_reg   <= '0;
                        full_reg   <= 1'b0;
                        if (cmd == CMD_DISCOVER)
                        begin
                            phase_reg <= PH_LOOK;
                            tgt_reg   <= first_probe;
                            state_reg <= S_SCAN;
                        end
                        else if (has_server_ident && server_ident != server_addr_reg)
                        begin
                            // foreign server: silent
                            done_reg <= 1'b1;
                        end
                        else if (!has_wanted)
                        begin
                            phase_reg <= PH_PROBE;
                            tgt_reg   <= first_probe;
                            state_reg <= S_SCAN;
                        end
                        else if ((wanted_addr & subnet_mask_reg)
                                 != (server_addr_reg & subnet_mask_reg))
                        begin
                            kind_reg  <= KIND_NAK;
                            cause_reg <= CAUSE_SUBNET;
                            done_reg  <= 1'b1;
                        end
                        else if (wanted_addr < pool_first_reg || wanted_addr > pool_last_reg)
                        begin
                            kind_reg  <= KIND_NAK;
                            cause_reg <= CAUSE_POOL;
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            phase_reg <= PH_WANT;
                            tgt_reg   <= wanted_addr;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    pend_reg     <= issue;
                    pend_idx_reg <= cnt_reg[IDX_W-1:0];
                    if (issue)
                        cnt_reg <= cnt_reg + 1'b1;
                    if (pend_reg)
                    begin
                        if (hw_hit && !hwf_reg)
                        begin
                            hwf_reg     <= 1'b1;
                            hw_idx_reg  <= pend_idx_reg;
                            hw_addr_reg <= rd_data_reg[ADDR_W-1:0];
                        end
                        if (!e_valid && !fr_reg)
                        begin
                            fr_reg     <= 1'b1;
                            fr_idx_reg <= pend_idx_reg;
                        end
                        if (addr_hit)
                            taken_reg <= 1'b1;
                        if (addr_hit && hw_hit)
                            owned_reg <= 1'b1;
                    end
                    if (!issue && !pend_reg)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (fin)
                    begin
                        kind_reg  <= fin_kind;
                        cause_reg <= fin_cause;
                        addr_reg  <= fin_addr;
                        full_reg  <= fin_full;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        // rescan for the next probe address, or for the first one after the lookup scan
                        if (next_probe)
                        begin
                            tgt_reg    <= skip_srv(probe_step, server_addr_reg,
                                                   pool_first_reg, pool_last_reg, srv_in);
                            nprobe_reg <= nprobe_reg + 1'b1;
                        end
                        else
                        begin
                            tgt_reg    <= first_probe;
                            nprobe_reg <= '0;
                        end
                        phase_reg <= PH_PROBE;
                        cnt_reg   <= '0;
                        hwf_reg   <= 1'b0;
                        fr_reg    <= 1'b0;
                        taken_reg <= 1'b0;
                        owned_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign reply_kind = kind_reg;
    assign given_addr = addr_reg;
    assign outcome    = full_reg;
    assign nak_cause  = cause_reg;

endmodule
